### hdl/trks_pkg.sv
// ----------------------------------------------------------------------------
// trks_pkg
// Shared types, constants and byte functions of the tweakey round key
// schedule: item structs, queued job type, byte permutation, LFSR and
// round constant table.
// ----------------------------------------------------------------------------
package trks_pkg;

  // Number of subtweakeys without the fork round
  localparam int Rounds = 14;
  localparam int RoundW = 6;
  localparam logic [31:0] Row0Const = 32'h0102_0408;

  typedef struct packed {
    logic [63:0] first_half_high;
    logic [63:0] first_half_low;
    logic [63:0] second_half_high;
    logic [63:0] second_half_low;
    logic        fork_extra_round;
  } in_t;

  typedef struct packed {
    logic [5:0]  round_index;
    logic [31:0] word_zero;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;
    logic        last_round;
  } out_t;

  // One classified tweakey waiting for the round engine
  typedef struct packed {
    logic [127:0]      first_half;
    logic [127:0]      second_half;
    logic [RoundW-1:0] final_round;
  } job_t;

  // Byte i (0 = most significant) moves to position perm_pos(i)
  function automatic logic [3:0] perm_pos(input logic [3:0] idx);
    logic [3:0] pos;
    unique case (idx)
      4'd0:  pos = 4'd1;
      4'd1:  pos = 4'd6;
      4'd2:  pos = 4'd11;
      4'd3:  pos = 4'd12;
      4'd4:  pos = 4'd5;
      4'd5:  pos = 4'd10;
      4'd6:  pos = 4'd15;
      4'd7:  pos = 4'd0;
      4'd8:  pos = 4'd9;
      4'd9:  pos = 4'd14;
      4'd10: pos = 4'd3;
      4'd11: pos = 4'd4;
      4'd12: pos = 4'd13;
      4'd13: pos = 4'd2;
      4'd14: pos = 4'd7;
      default: pos = 4'd8;
    endcase
    return pos;
  endfunction

  // Byte permutation of one 128-bit half, byte 0 at the top
  function automatic logic [127:0] permute_half(input logic [127:0] src);
    logic [127:0] dst;
    logic [3:0]   pos;
    dst = '0;
    for (int i = 0; i < 16; i++) begin
      pos = perm_pos(4'(i));
      dst[127 - 8*pos -: 8] = src[127 - 8*i -: 8];
    end
    return dst;
  endfunction

  // Per-byte LFSR: shift left, feed bit5 ^ bit7 in at the bottom
  function automatic logic [127:0] lfsr_half(input logic [127:0] src);
    logic [127:0] dst;
    logic [7:0]   b;
    dst = '0;
    for (int i = 0; i < 16; i++) begin
      b = src[8*i +: 8];
      dst[8*i +: 8] = {b[6:0], b[5] ^ b[7]};
    end
    return dst;
  endfunction

  // Round constant byte, 40 entries
  function automatic logic [7:0] round_const(input logic [RoundW-1:0] idx);
    logic [7:0] rc;
    unique case (idx)
      6'd0:  rc = 8'h2f;  6'd1:  rc = 8'h5e;  6'd2:  rc = 8'hbc;  6'd3:  rc = 8'h63;
      6'd4:  rc = 8'hc6;  6'd5:  rc = 8'h97;  6'd6:  rc = 8'h35;  6'd7:  rc = 8'h6a;
      6'd8:  rc = 8'hd4;  6'd9:  rc = 8'hb3;  6'd10: rc = 8'h7d;  6'd11: rc = 8'hfa;
      6'd12: rc = 8'hef;  6'd13: rc = 8'hc5;  6'd14: rc = 8'h91;  6'd15: rc = 8'h39;
      6'd16: rc = 8'h72;  6'd17: rc = 8'he4;  6'd18: rc = 8'hd3;  6'd19: rc = 8'hbd;
      6'd20: rc = 8'h61;  6'd21: rc = 8'hc2;  6'd22: rc = 8'h9f;  6'd23: rc = 8'h25;
      6'd24: rc = 8'h4a;  6'd25: rc = 8'h94;  6'd26: rc = 8'h33;  6'd27: rc = 8'h66;
      6'd28: rc = 8'hcc;  6'd29: rc = 8'h83;  6'd30: rc = 8'h1d;  6'd31: rc = 8'h3a;
      6'd32: rc = 8'h74;  6'd33: rc = 8'he8;  6'd34: rc = 8'hcb;  6'd35: rc = 8'h8d;
      6'd36: rc = 8'h01;  6'd37: rc = 8'h02;  6'd38: rc = 8'h04;  6'd39: rc = 8'h08;
      // Round index stays below 40 for every allowed round count
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

endpackage

### hdl/trks_front.sv
// ----------------------------------------------------------------------------
// trks_front
// Input side: accepts tweakey beats, works out the index of the last
// round and holds up to two jobs for the round engine.
// ----------------------------------------------------------------------------
module trks_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  trks_pkg::in_t   in_data,
  output logic            full,
  output logic            job_valid,
  output trks_pkg::job_t  job,
  input  logic            job_take
);

  trks_pkg::job_t job_mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push, do_pop;
  trks_pkg::job_t new_job;

  // Classify the beat: last round is Rounds - 1, one more with the fork flag
  always_comb begin
    new_job.first_half  = {in_data.first_half_high, in_data.first_half_low};
    new_job.second_half = {in_data.second_half_high, in_data.second_half_low};
    new_job.final_round = trks_pkg::RoundW'(trks_pkg::Rounds - 1)
                        + {{(trks_pkg::RoundW-1){1'b0}}, in_data.fork_extra_round};
  end

  assign full      = count_r[1];
  assign job_valid = (count_r != 2'd0);
  assign job       = job_mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = job_take && job_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified job
  always_ff @(posedge clk) begin
    if (do_push) begin
      job_mem_r[wr_ptr_r] <= new_job;
    end
  end

endmodule

### hdl/trks_back.sv
// ----------------------------------------------------------------------------
// trks_back
// Round engine: steps both halves through the schedule into an output register
// that the receiver drains, one subtweakey per cycle while that register is free or popped.
// ----------------------------------------------------------------------------
module trks_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  trks_pkg::job_t  job,
  output logic            job_take,
  output logic            res_valid,
  output trks_pkg::out_t  res,
  input  logic            res_pop
);

  logic                        busy_r, busy_nxt;
  logic [127:0]                first_r, first_nxt;
  logic [127:0]                second_r, second_nxt;
  logic [trks_pkg::RoundW-1:0] round_r, round_nxt;
  logic [trks_pkg::RoundW-1:0] final_r, final_nxt;
  logic                        res_valid_r, res_valid_nxt;
  trks_pkg::out_t              res_r;
  trks_pkg::out_t              cur;
  logic                        slot_free, advance, is_last;
  logic [127:0]                mix;
  logic [7:0]                  rc;

  assign slot_free = !res_valid_r || res_pop;
  assign advance   = busy_r && slot_free;
  assign is_last   = (round_r == final_r);
  assign job_take  = job_valid && (!busy_r || (advance && is_last));

  // Form this round's subtweakey
  always_comb begin
    mix = first_r ^ second_r;
    rc  = trks_pkg::round_const(round_r);
    cur.round_index = round_r;
    cur.word_zero   = mix[127:96] ^ trks_pkg::Row0Const;
    cur.word_one    = mix[95:64] ^ {4{rc}};
    cur.word_two    = mix[63:32];
    cur.word_three  = mix[31:0];
    cur.last_round  = is_last;
  end

  // Load a new job or step the halves after each emitted round
  always_comb begin
    busy_nxt   = busy_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    round_nxt  = round_r;
    final_nxt  = final_r;
    if (advance) begin
      first_nxt  = trks_pkg::lfsr_half(trks_pkg::permute_half(first_r));
      second_nxt = trks_pkg::permute_half(second_r);
      round_nxt  = round_r + 1'b1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (job_take) begin
      busy_nxt   = 1'b1;
      first_nxt  = job.first_half;
      second_nxt = job.second_half;
      round_nxt  = '0;
      final_nxt  = job.final_round;
    end
  end

  // Hold the result until popped
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (advance) begin
      res_valid_nxt = 1'b1;
    end else if (res_pop) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      res_valid_r <= 1'b0;
      round_r     <= '0;
      final_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      res_valid_r <= res_valid_nxt;
      round_r     <= round_nxt;
      final_r     <= final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    second_r <= second_nxt;
    if (advance) begin
      res_r <= cur;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

### hdl/tweakey_round_key_schedule_unit.sv
// ----------------------------------------------------------------------------
// tweakey_round_key_schedule_unit
// Tweakey schedule: expands one 256-bit tweakey into its round subtweakeys.
// ----------------------------------------------------------------------------
// Input channel: write a tweakey beat with in_push while in_full is low.
// The beat is classified and parked in a two-entry job queue.
// Result channel: while out_empty is low, out_data holds the oldest
// subtweakey; out_pop takes it. Each tweakey yields 14 subtweakeys, 15 when
// fork_extra_round is set, with last_round marking the final one.
// A beat taken by an idle block is written to the job queue, loaded into
// the round engine's state registers, and its first subtweakey then lands
// in the output register. Throughput: one subtweakey per cycle while the
// receiver keeps popping, from the round engine's single state register
// pair; the next job loads in the cycle its predecessor's last round leaves.
// Reset (rst_n low at a clock edge) empties the job queue, stops the
// engine and drops any waiting subtweakey.
// When the receiver stalls, the engine holds its round and the queue fills;
// in_full rises once two tweakeys are waiting.
// ----------------------------------------------------------------------------
module tweakey_round_key_schedule_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  trks_pkg::in_t   in_data,
  output logic            in_full,
  output logic            out_empty,
  output trks_pkg::out_t  out_data,
  input  logic            out_pop
);

  logic           job_valid, job_take, res_valid;
  trks_pkg::job_t job;

  trks_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .in_data   (in_data),
    .full      (in_full),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  trks_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .res_valid (res_valid),
    .res       (out_data),
    .res_pop   (out_pop)
  );

  assign out_empty = !res_valid;

endmodule

### bench/tweakey_round_key_schedule_unit_test.sv
// ----------------------------------------------------------------------------
// tweakey_round_key_schedule_unit_test
// Self-checking bench for the tweakey schedule. Tweakey beats are queued up
// front, pushed with random idle bursts and, now and then, held back until
// every subtweakey of the tweakeys already sent has arrived. Each accepted
// beat is expanded by a local schedule model into its subtweakeys. Every
// popped subtweakey is compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
module tweakey_round_key_schedule_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;
  localparam int RandomItems = 160;
  localparam int QuietTail   = 25;

  // Destination of each byte under the schedule's byte shuffle
  localparam int BytePerm [16] = '{1, 6, 11, 12, 5, 10, 15, 0,
                                   9, 14, 3, 4, 13, 2, 7, 8};

  localparam logic [7:0] RoundConstByte [40] = '{
    8'h2f, 8'h5e, 8'hbc, 8'h63, 8'hc6, 8'h97, 8'h35, 8'h6a, 8'hd4, 8'hb3,
    8'h7d, 8'hfa, 8'hef, 8'hc5, 8'h91, 8'h39, 8'h72, 8'he4, 8'hd3, 8'hbd,
    8'h61, 8'hc2, 8'h9f, 8'h25, 8'h4a, 8'h94, 8'h33, 8'h66, 8'hcc, 8'h83,
    8'h1d, 8'h3a, 8'h74, 8'he8, 8'hcb, 8'h8d, 8'h01, 8'h02, 8'h04, 8'h08};

  typedef struct {
    trks_pkg::in_t tweakey;
    bit            drain_first;
  } pending_tweakey_t;

  logic           clk;
  logic           rst_n    = 1'b0;
  logic           in_push  = 1'b0;
  trks_pkg::in_t  in_data  = '0;
  logic           in_full;
  logic           out_empty;
  trks_pkg::out_t out_data;
  logic           out_pop  = 1'b0;

  pending_tweakey_t tweakey_queue[$];
  trks_pkg::out_t   expected_subtweakeys[$];

  logic in_beat_taken = 1'b0;
  int   cycle_count   = 0;
  int   fail_count    = 0;
  int   beats_checked = 0;
  int   tweakeys_sent = 0;
  int   fork_tweakeys = 0;
  int   send_gap      = 0;
  int   recv_stall    = 0;

  tweakey_round_key_schedule_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_data (out_data),
    .out_pop  (out_pop)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Move byte i (0 at the top) to position BytePerm[i]
  function automatic logic [127:0] shuffle_bytes(input logic [127:0] src);
    logic [127:0] dst;
    dst = '0;
    for (int i = 0; i < 16; i++) begin
      dst[127 - 8*BytePerm[i] -: 8] = src[127 - 8*i -: 8];
    end
    return dst;
  endfunction

  // Clock every byte's LFSR once: shift left, feed bit 7 ^ bit 5 back in
  function automatic logic [127:0] clock_byte_lfsrs(input logic [127:0] src);
    logic [127:0] dst;
    logic [7:0]   b;
    dst = '0;
    for (int i = 0; i < 16; i++) begin
      b = src[8*i +: 8];
      dst[8*i +: 8] = {b[6:0], b[7] ^ b[5]};
    end
    return dst;
  endfunction

  // Expand one tweakey into its subtweakeys and queue them
  function automatic void expand_tweakey(input trks_pkg::in_t tk);
    logic [127:0]   first_half;
    logic [127:0]   second_half;
    logic [127:0]   mixed;
    logic [7:0]     rc;
    trks_pkg::out_t sub;
    int             count;
    first_half  = {tk.first_half_high, tk.first_half_low};
    second_half = {tk.second_half_high, tk.second_half_low};
    count       = trks_pkg::Rounds + int'(tk.fork_extra_round);
    for (int r = 0; r < count; r++) begin
      mixed            = first_half ^ second_half;
      rc               = RoundConstByte[r % 40];
      sub.round_index  = 6'(r);
      sub.word_zero    = mixed[127:96] ^ trks_pkg::Row0Const;
      sub.word_one     = mixed[95:64] ^ {4{rc}};
      sub.word_two     = mixed[63:32];
      sub.word_three   = mixed[31:0];
      sub.last_round   = (r == count - 1);
      expected_subtweakeys.push_back(sub);
      first_half  = clock_byte_lfsrs(shuffle_bytes(first_half));
      second_half = shuffle_bytes(second_half);
    end
  endfunction

  task automatic add_tweakey(input logic [63:0] fh_hi, input logic [63:0] fh_lo,
                             input logic [63:0] sh_hi, input logic [63:0] sh_lo,
                             input logic fork_round, input bit drain);
    pending_tweakey_t item;
    item.tweakey.first_half_high  = fh_hi;
    item.tweakey.first_half_low   = fh_lo;
    item.tweakey.second_half_high = sh_hi;
    item.tweakey.second_half_low  = sh_lo;
    item.tweakey.fork_extra_round = fork_round;
    item.drain_first              = drain;
    tweakey_queue.push_back(item);
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Bytes picked from values that sit on the LFSR taps and the extremes
  function automatic logic [63:0] tap_pattern_word();
    logic [63:0] w;
    logic [7:0]  picks [6];
    picks = '{8'h00, 8'hff, 8'h80, 8'h20, 8'ha0, 8'h01};
    for (int i = 0; i < 8; i++) begin
      w[8*i +: 8] = picks[$urandom_range(0, 5)];
    end
    return w;
  endfunction

  // Sender: hold a beat until taken, then idle or fetch the next tweakey
  always @(negedge clk) begin : sender
    logic          push_next;
    trks_pkg::in_t data_next;
    push_next = in_push;
    data_next = in_data;
    if (!rst_n) begin
      push_next = 1'b0;
    end else if (!(in_push && !in_beat_taken)) begin
      push_next = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (tweakey_queue.size() > 0 &&
                   !(tweakey_queue[0].drain_first && expected_subtweakeys.size() > 0)) begin
        data_next = tweakey_queue[0].tweakey;
        tweakey_queue.pop_front();
        push_next = 1'b1;
        if (tweakey_queue.size() >= QuietTail && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(1, 14);
        end
      end
    end
    in_push <= push_next;
    in_data <= data_next;
  end

  // Receiver: pop freely, with random stall bursts until the quiet tail
  always @(negedge clk) begin : receiver
    logic pop_next;
    if (!rst_n) begin
      pop_next = 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      pop_next = 1'b0;
    end else begin
      pop_next = 1'b1;
      if (tweakey_queue.size() >= QuietTail && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(1, 14);
      end
    end
    out_pop <= pop_next;
  end

  // Monitor: check popped subtweakeys, expand accepted tweakeys
  always @(posedge clk) begin : monitor
    trks_pkg::out_t want;
    cycle_count++;
    in_beat_taken <= rst_n && in_push && !in_full;
    if (rst_n && !out_empty && out_pop) begin
      if (expected_subtweakeys.size() == 0) begin
        $error("subtweakey beat with no expectation waiting: round_index %0d",
               out_data.round_index);
        fail_count++;
      end else begin
        want = expected_subtweakeys.pop_front();
        beats_checked++;
        if (out_data.round_index !== want.round_index) begin
          $error("round_index: expected %0d, got %0d", want.round_index,
                 out_data.round_index);
          fail_count++;
        end
        if (out_data.word_zero !== want.word_zero) begin
          $error("word_zero: expected %08h, got %08h", want.word_zero, out_data.word_zero);
          fail_count++;
        end
        if (out_data.word_one !== want.word_one) begin
          $error("word_one: expected %08h, got %08h", want.word_one, out_data.word_one);
          fail_count++;
        end
        if (out_data.word_two !== want.word_two) begin
          $error("word_two: expected %08h, got %08h", want.word_two, out_data.word_two);
          fail_count++;
        end
        if (out_data.word_three !== want.word_three) begin
          $error("word_three: expected %08h, got %08h", want.word_three,
                 out_data.word_three);
          fail_count++;
        end
        if (out_data.last_round !== want.last_round) begin
          $error("last_round: expected %0b, got %0b", want.last_round, out_data.last_round);
          fail_count++;
        end
      end
    end
    if (rst_n && in_push && !in_full) begin
      expand_tweakey(in_data);
      tweakeys_sent++;
      if (in_data.fork_extra_round) begin
        fork_tweakeys++;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    // Directed: extremes, equal and complementary halves, both fork settings
    add_tweakey('0, '0, '0, '0, 1'b0, 1'b0);
    add_tweakey('0, '0, '0, '0, 1'b1, 1'b0);
    add_tweakey('1, '1, '1, '1, 1'b0, 1'b0);
    add_tweakey('1, '1, '1, '1, 1'b1, 1'b0);
    add_tweakey('1, '1, '0, '0, 1'b1, 1'b1);
    add_tweakey('0, '0, '1, '1, 1'b0, 1'b0);
    add_tweakey({8{8'haa}}, {8{8'haa}}, {8{8'h55}}, {8{8'h55}}, 1'b1, 1'b0);
    add_tweakey({8{8'h55}}, {8{8'h55}}, {8{8'haa}}, {8{8'haa}}, 1'b0, 1'b0);
    add_tweakey(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                64'h1011_1213_1415_1617, 64'h1819_1a1b_1c1d_1e1f, 1'b1, 1'b0);
    add_tweakey(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, 1'b0, 1'b1);
    add_tweakey({8{8'h20}}, {8{8'h80}}, {8{8'ha0}}, {8{8'h01}}, 1'b1, 1'b0);
    add_tweakey(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
    add_tweakey(64'hfefc_f8f0_e0c0_8000, 64'h0102_0408_1020_4080,
                64'h0102_0408_2f2f_2f2f, '0, 1'b1, 1'b0);

    // Random: mostly full-width noise, some tap-heavy byte patterns
    for (int n = 0; n < RandomItems; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        add_tweakey(random_word(), random_word(), random_word(), random_word(),
                    1'($urandom_range(0, 1)), (n % 40) == 20);
      end else begin
        add_tweakey(tap_pattern_word(), tap_pattern_word(), tap_pattern_word(),
                    tap_pattern_word(), 1'($urandom_range(0, 1)), (n % 40) == 20);
      end
    end

    // Release reset on a falling clock edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain stimulus, then expectations, then let the block settle
    while (tweakey_queue.size() > 0 || in_push) @(posedge clk);
    while (expected_subtweakeys.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d subtweakeys from %0d tweakeys, %0d of them with the fork round.",
             beats_checked, tweakeys_sent, fork_tweakeys);
    $display("Field mismatches or stray beats: %0d.", fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### tweakey_round_key_schedule_unit.f
hdl/trks_pkg.sv
hdl/trks_front.sv
hdl/trks_back.sv
hdl/tweakey_round_key_schedule_unit.sv
bench/tweakey_round_key_schedule_unit_test.sv
